/* design/cfe_pkg.sv */
// Shared constants, codes and control structs of the CSV field extract unit.
package cfe_pkg;

    localparam int KEY_BYTES   = 3;
    localparam int DELAY_BITS  = 16;
    localparam int BUCKET_BITS = 12;

    localparam int KEY_W      = 8 * KEY_BYTES;
    localparam int ACC_W      = DELAY_BITS + 1;
    localparam int OFF_W      = $clog2(KEY_BYTES + 1);
    localparam int PEND_W     = OFF_W;
    localparam int CNT_W      = 6;
    localparam int FIELD_W    = 6;
    localparam int SEED_W     = 12;
    localparam int BCNT_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CNT_W-1:0] COUNT_MAX  = 6'd63;
    localparam logic [7:0]       COMMA_CHAR = 8'h2C;

    localparam logic [FIELD_W-1:0] DAY_FIELD_RESET    = 6'd4;
    localparam logic [FIELD_W-1:0] DELAY_FIELD_RESET  = 6'd15;
    localparam logic [FIELD_W-1:0] ORIGIN_FIELD_RESET = 6'd17;
    localparam logic [FIELD_W-1:0] DEST_FIELD_RESET   = 6'd18;
    localparam logic [SEED_W-1:0]  SEED_RESET         = 12'd2109;
    localparam logic [BCNT_W-1:0]  BUCKETS_RESET      = 13'd500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DAY_FIELD    = 3'd0,
        CFG_DELAY_FIELD  = 3'd1,
        CFG_ORIGIN_FIELD = 3'd2,
        CFG_DEST_FIELD   = 3'd3,
        CFG_HASH_SEED    = 3'd4,
        CFG_BUCKET_COUNT = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic step;
        logic line_done;
        logic load_out;
    } cfe_cmd_t;

    typedef struct packed {
        logic hash_busy;
    } cfe_status_t;

endpackage

/* design/cfe_ctrl.sv */
// Controller state machine: byte acceptance, hash wait and output register valid.
module cfe_ctrl
    import cfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        line_end,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  cfe_status_t status,
    output cfe_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HASH = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd.step      = 1'b0;
        cmd.line_done = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.step = 1'b1;
                    if (line_end)
                    begin
                        cmd.line_done = 1'b1;
                        state_next    = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                if (!status.hash_busy && out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* design/cfe_hash.sv */
// Key hash datapath: multiply-accumulate per key byte and bit-serial modulo reduction.
module cfe_hash
    import cfe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   start,
    input  logic [KEY_W-1:0]       key,
    output logic                   busy,
    output logic [BUCKET_BITS-1:0] bucket
);

    localparam int M_W    = BUCKET_BITS + 1;
    localparam int CMP_W  = (M_W > BCNT_W) ? M_W : BCNT_W;
    localparam int MUL_W  = BUCKET_BITS + SEED_W;
    localparam int PROD_W = MUL_W + 1;
    localparam int BIT_W  = $clog2(PROD_W);
    localparam int LEFT_W = $clog2(KEY_BYTES + 1);

    logic [SEED_W-1:0]      seed_reg;
    logic [BCNT_W-1:0]      count_reg;
    logic [M_W-1:0]         m_reg;
    logic [M_W-1:0]         m_eff;
    logic [CMP_W-1:0]       count_wide;
    logic [KEY_W-1:0]       key_reg;
    logic [LEFT_W-1:0]      left_reg;
    logic [BUCKET_BITS-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0]      div_reg;
    logic [BIT_W-1:0]       bit_reg;
    logic                   busy_reg;
    logic                   reduce_reg;
    logic [7:0]             top_byte;
    logic [MUL_W-1:0]       mul;
    logic [PROD_W-1:0]      prod;
    logic [M_W-1:0]         shifted;
    logic                   byte_stop;

    assign count_wide = CMP_W'(count_reg);

    always_comb
    begin
        if (count_reg == '0)
        begin
            m_eff = M_W'(1);
        end
        else if (count_wide > (CMP_W'(1) << BUCKET_BITS))
        begin
            m_eff = M_W'(1) << BUCKET_BITS;
        end
        else
        begin
            m_eff = M_W'(count_wide);
        end
    end

    assign top_byte  = key_reg[KEY_W-1 -: 8];
    assign byte_stop = (left_reg == '0) || (top_byte == 8'd0);
    assign mul       = rem_reg * seed_reg;
    assign prod      = {1'b0, mul} + PROD_W'(top_byte);
    assign shifted   = {rem_reg, div_reg[PROD_W-1]};

    always_comb
    begin
        if (shifted >= m_reg)
        begin
            rem_next = BUCKET_BITS'(shifted - m_reg);
        end
        else
        begin
            rem_next = BUCKET_BITS'(shifted);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= SEED_RESET;
            count_reg  <= BUCKETS_RESET;
            busy_reg   <= 1'b0;
            reduce_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_HASH_SEED:    seed_reg  <= cfg_data[SEED_W-1:0];
                    CFG_BUCKET_COUNT: count_reg <= cfg_data[BCNT_W-1:0];
                    default:          ;
                endcase
            end
            if (start)
            begin
                busy_reg   <= 1'b1;
                reduce_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                if (!reduce_reg)
                begin
                    if (byte_stop)
                    begin
                        busy_reg <= 1'b0;
                    end
                    else
                    begin
                        reduce_reg <= 1'b1;
                    end
                end
                else if (bit_reg == '0)
                begin
                    reduce_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg  <= key;
            left_reg <= LEFT_W'(KEY_BYTES);
            rem_reg  <= '0;
            m_reg    <= m_eff;
        end
        else if (busy_reg)
        begin
            if (!reduce_reg)
            begin
                if (!byte_stop)
                begin
                    div_reg  <= prod;
                    key_reg  <= key_reg << 8;
                    left_reg <= left_reg - 1'b1;
                    rem_reg  <= '0;
                    bit_reg  <= BIT_W'(PROD_W - 1);
                end
            end
            else
            begin
                rem_reg <= rem_next;
                div_reg <= div_reg << 1;
                bit_reg <= bit_reg - 1'b1;
            end
        end
    end

    assign busy   = busy_reg;
    assign bucket = rem_reg;

endmodule

/* design/cfe_parser.sv */
// Byte parser datapath: comma count, number fields, key capture and result registers.
module cfe_parser
    import cfe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  cfe_cmd_t               cmd,
    input  logic [7:0]             text_byte,
    input  logic                   line_end,
    input  logic                   batch_start,
    input  logic [BUCKET_BITS-1:0] bucket,
    output logic [KEY_W-1:0]       hash_key,
    output logic [3:0]             day_of_week,
    output logic                   day_valid,
    output logic [DELAY_BITS-1:0]  delay_value,
    output logic                   delay_clipped,
    output logic [KEY_W-1:0]       origin_key,
    output logic [KEY_W-1:0]       dest_key,
    output logic [BUCKET_BITS-1:0] bucket_index
);

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } number_phase_t;

    localparam int GROW_W = ACC_W + 4;
    localparam logic [ACC_W-1:0] ACC_CAP    = ACC_W'(1) << DELAY_BITS;
    localparam logic [ACC_W-1:0] DELAY_HALF = ACC_W'(1) << (DELAY_BITS - 1);

    logic [FIELD_W-1:0] day_num_reg, delay_num_reg, origin_num_reg, dest_num_reg;

    logic [CNT_W-1:0]      comma_count_reg, comma_count_next;
    logic [OFF_W-1:0]      field_offset_reg, field_offset_next;
    number_phase_t         number_phase_reg, number_phase_next;
    logic                  number_negative_reg, number_negative_next;
    logic [ACC_W-1:0]      number_accum_reg, number_accum_next;
    logic [3:0]            day_hold_reg, day_hold_next;
    logic [DELAY_BITS-1:0] delay_hold_reg, delay_hold_next;
    logic                  delay_clip_reg, delay_clip_next;
    logic [KEY_W-1:0]      key_window_reg, key_window_next;
    logic [KEY_W-1:0]      origin_hold_reg, origin_hold_next;
    logic [KEY_W-1:0]      dest_hold_reg, dest_hold_next;
    logic [PEND_W-1:0]     origin_pend_reg, origin_pend_next;
    logic [PEND_W-1:0]     dest_pend_reg, dest_pend_next;

    logic [3:0]            snap_day_reg;
    logic [DELAY_BITS-1:0] snap_delay_reg;
    logic                  snap_clip_reg;
    logic [KEY_W-1:0]      snap_origin_reg, snap_dest_reg;

    logic [3:0]             out_day_reg;
    logic                   out_day_valid_reg;
    logic [DELAY_BITS-1:0]  out_delay_reg;
    logic                   out_clip_reg;
    logic [KEY_W-1:0]       out_origin_reg, out_dest_reg;
    logic [BUCKET_BITS-1:0] out_bucket_reg;

    logic                  is_comma, is_digit, is_space, is_sign;
    logic [GROW_W-1:0]     grown;
    logic [ACC_W-1:0]      magnitude;

    assign is_comma = (text_byte == COMMA_CHAR);
    assign is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
    assign is_space = (text_byte == 8'h20) || ((text_byte >= 8'h09) && (text_byte <= 8'h0D));
    assign is_sign  = (text_byte == 8'h2B) || (text_byte == 8'h2D);

    always_comb
    begin
        comma_count_next     = comma_count_reg;
        field_offset_next    = field_offset_reg;
        number_phase_next    = number_phase_reg;
        number_negative_next = number_negative_reg;
        number_accum_next    = number_accum_reg;
        day_hold_next        = day_hold_reg;
        delay_hold_next      = delay_hold_reg;
        delay_clip_next      = delay_clip_reg;
        key_window_next      = key_window_reg;
        origin_hold_next     = origin_hold_reg;
        dest_hold_next       = dest_hold_reg;
        origin_pend_next     = origin_pend_reg;
        dest_pend_next       = dest_pend_reg;
        magnitude            = '0;

        if (batch_start)
        begin
            comma_count_next     = '0;
            field_offset_next    = '0;
            number_phase_next    = PH_SKIP;
            number_negative_next = 1'b0;
            number_accum_next    = '0;
            day_hold_next        = '0;
            delay_hold_next      = '0;
            delay_clip_next      = 1'b0;
            key_window_next      = '0;
            origin_hold_next     = '0;
            dest_hold_next       = '0;
            origin_pend_next     = '0;
            dest_pend_next       = '0;
        end

        if (origin_pend_next != '0)
        begin
            origin_hold_next = (origin_hold_next << 8) | KEY_W'(text_byte);
            origin_pend_next = origin_pend_next - 1'b1;
        end
        if (dest_pend_next != '0)
        begin
            dest_hold_next = (dest_hold_next << 8) | KEY_W'(text_byte);
            dest_pend_next = dest_pend_next - 1'b1;
        end

        grown = (GROW_W'(number_accum_next) << 3) + (GROW_W'(number_accum_next) << 1)
              + GROW_W'(text_byte[3:0]);

        if (is_comma)
        begin
            if (comma_count_next < COUNT_MAX)
            begin
                comma_count_next = comma_count_next + 1'b1;
                if (comma_count_next == day_num_reg)
                begin
                    if (number_negative_next || (number_accum_next == '0))
                    begin
                        day_hold_next = 4'd0;
                    end
                    else if (number_accum_next > ACC_W'(15))
                    begin
                        day_hold_next = 4'd15;
                    end
                    else
                    begin
                        day_hold_next = number_accum_next[3:0];
                    end
                end
                if (comma_count_next == delay_num_reg)
                begin
                    delay_clip_next = 1'b0;
                    magnitude       = number_accum_next;
                    if (number_negative_next)
                    begin
                        if (magnitude > DELAY_HALF)
                        begin
                            magnitude       = DELAY_HALF;
                            delay_clip_next = 1'b1;
                        end
                        delay_hold_next = DELAY_BITS'(ACC_W'(0) - magnitude);
                    end
                    else
                    begin
                        if (magnitude > (DELAY_HALF - 1'b1))
                        begin
                            magnitude       = DELAY_HALF - 1'b1;
                            delay_clip_next = 1'b1;
                        end
                        delay_hold_next = magnitude[DELAY_BITS-1:0];
                    end
                end
                if (comma_count_next == origin_num_reg)
                begin
                    if (field_offset_next >= OFF_W'(KEY_BYTES))
                    begin
                        origin_hold_next = key_window_next;
                        origin_pend_next = '0;
                    end
                    else
                    begin
                        origin_hold_next = (key_window_next << 8) | KEY_W'(COMMA_CHAR);
                        origin_pend_next = PEND_W'(KEY_BYTES - 1) - PEND_W'(field_offset_next);
                    end
                end
                if (comma_count_next == dest_num_reg)
                begin
                    if (field_offset_next >= OFF_W'(KEY_BYTES))
                    begin
                        dest_hold_next = key_window_next;
                        dest_pend_next = '0;
                    end
                    else
                    begin
                        dest_hold_next = (key_window_next << 8) | KEY_W'(COMMA_CHAR);
                        dest_pend_next = PEND_W'(KEY_BYTES - 1) - PEND_W'(field_offset_next);
                    end
                end
            end
            number_phase_next    = PH_SKIP;
            number_negative_next = 1'b0;
            number_accum_next    = '0;
            key_window_next      = '0;
            field_offset_next    = '0;
        end
        else
        begin
            if ((number_phase_next == PH_SKIP) && is_space)
            begin
                number_phase_next = PH_SKIP;
            end
            else if ((number_phase_next == PH_SKIP) && is_sign)
            begin
                number_negative_next = (text_byte == 8'h2D);
                number_phase_next    = PH_SIGN;
            end
            else if (number_phase_next != PH_DONE)
            begin
                if (is_digit)
                begin
                    if (grown > GROW_W'(ACC_CAP))
                    begin
                        number_accum_next = ACC_CAP;
                    end
                    else
                    begin
                        number_accum_next = ACC_W'(grown);
                    end
                    number_phase_next = PH_DIGITS;
                end
                else
                begin
                    number_phase_next = PH_DONE;
                end
            end
            if (field_offset_next < OFF_W'(KEY_BYTES))
            begin
                key_window_next   = (key_window_next << 8) | KEY_W'(text_byte);
                field_offset_next = field_offset_next + 1'b1;
            end
        end

        if (line_end)
        begin
            origin_hold_next     = origin_hold_next << {origin_pend_next, 3'b000};
            dest_hold_next       = dest_hold_next << {dest_pend_next, 3'b000};
            origin_pend_next     = '0;
            dest_pend_next       = '0;
        end
    end

    // The finished line values feed the snapshot and the hash before the line is cleared.
    assign hash_key = origin_hold_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_num_reg         <= DAY_FIELD_RESET;
            delay_num_reg       <= DELAY_FIELD_RESET;
            origin_num_reg      <= ORIGIN_FIELD_RESET;
            dest_num_reg        <= DEST_FIELD_RESET;
            comma_count_reg     <= '0;
            field_offset_reg    <= '0;
            number_phase_reg    <= PH_SKIP;
            number_negative_reg <= 1'b0;
            number_accum_reg    <= '0;
            day_hold_reg        <= '0;
            delay_hold_reg      <= '0;
            delay_clip_reg      <= 1'b0;
            key_window_reg      <= '0;
            origin_hold_reg     <= '0;
            dest_hold_reg       <= '0;
            origin_pend_reg     <= '0;
            dest_pend_reg       <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_DAY_FIELD:    day_num_reg    <= cfg_data[FIELD_W-1:0];
                    CFG_DELAY_FIELD:  delay_num_reg  <= cfg_data[FIELD_W-1:0];
                    CFG_ORIGIN_FIELD: origin_num_reg <= cfg_data[FIELD_W-1:0];
                    CFG_DEST_FIELD:   dest_num_reg   <= cfg_data[FIELD_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.step)
            begin
                origin_hold_reg <= origin_hold_next;
                dest_hold_reg   <= dest_hold_next;
                origin_pend_reg <= origin_pend_next;
                dest_pend_reg   <= dest_pend_next;
                if (line_end)
                begin
                    comma_count_reg     <= '0;
                    field_offset_reg    <= '0;
                    number_phase_reg    <= PH_SKIP;
                    number_negative_reg <= 1'b0;
                    number_accum_reg    <= '0;
                    day_hold_reg        <= '0;
                    delay_hold_reg      <= '0;
                    delay_clip_reg      <= 1'b0;
                    key_window_reg      <= '0;
                end
                else
                begin
                    comma_count_reg     <= comma_count_next;
                    field_offset_reg    <= field_offset_next;
                    number_phase_reg    <= number_phase_next;
                    number_negative_reg <= number_negative_next;
                    number_accum_reg    <= number_accum_next;
                    day_hold_reg        <= day_hold_next;
                    delay_hold_reg      <= delay_hold_next;
                    delay_clip_reg      <= delay_clip_next;
                    key_window_reg      <= key_window_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.line_done)
        begin
            snap_day_reg    <= day_hold_next;
            snap_delay_reg  <= delay_hold_next;
            snap_clip_reg   <= delay_clip_next;
            snap_origin_reg <= origin_hold_next;
            snap_dest_reg   <= dest_hold_next;
        end
        if (cmd.load_out)
        begin
            out_day_reg       <= snap_day_reg;
            out_day_valid_reg <= (snap_day_reg >= 4'd1) && (snap_day_reg <= 4'd7);
            out_delay_reg     <= snap_delay_reg;
            out_clip_reg      <= snap_clip_reg;
            out_origin_reg    <= snap_origin_reg;
            out_dest_reg      <= snap_dest_reg;
            out_bucket_reg    <= bucket;
        end
    end

    assign day_of_week   = out_day_reg;
    assign day_valid     = out_day_valid_reg;
    assign delay_value   = out_delay_reg;
    assign delay_clipped = out_clip_reg;
    assign origin_key    = out_origin_reg;
    assign dest_key      = out_dest_reg;
    assign bucket_index  = out_bucket_reg;

endmodule

/* design/csv_flight_record_field_extract_unit.sv */
// Top level of the CSV flight record field extract unit.
//
//  channel  | handshake               | beat payload
//  ---------+-------------------------+-------------------------------------------------
//  input    | in_valid / in_ready     | text_byte, line_end, batch_start
//  output   | out_valid / out_ready   | day_of_week, day_valid, delay_value,
//           |                         | delay_clipped, origin_key, dest_key, bucket_index
//  config   | cfg_write               | cfg_index, cfg_data
//
// An ordinary byte is taken whenever in_valid is high in the idle state. A line-end byte
// holds the input while the nonzero leading origin key bytes (0 to 3) are hashed, the
// modulo unit reducing one dividend bit per cycle. Reset presets the control, parse and
// config registers with no clearing pass; hash work, snapshot and output data registers
// are not reset. A finished result waits in the output register while the next line's
// bytes are taken; after the next line end the input waits until that result is taken.
module csv_flight_record_field_extract_unit
    import cfe_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    text_byte,
    input  logic                          line_end,
    input  logic                          batch_start,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3:0]                    day_of_week,
    output logic                          day_valid,
    output logic signed [DELAY_BITS-1:0]  delay_value,
    output logic                          delay_clipped,
    output logic [KEY_W-1:0]              origin_key,
    output logic [KEY_W-1:0]              dest_key,
    output logic [BUCKET_BITS-1:0]        bucket_index,
    input  logic                          cfg_write,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    cfe_cmd_t               cmd;
    cfe_status_t            status;
    logic [KEY_W-1:0]       hash_key;
    logic [BUCKET_BITS-1:0] bucket;
    logic                   hash_busy;
    logic [DELAY_BITS-1:0]  delay_bits;

    assign status.hash_busy = hash_busy;
    assign delay_value      = delay_bits;

    cfe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .line_end  (line_end),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    cfe_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .text_byte     (text_byte),
        .line_end      (line_end),
        .batch_start   (batch_start),
        .bucket        (bucket),
        .hash_key      (hash_key),
        .day_of_week   (day_of_week),
        .day_valid     (day_valid),
        .delay_value   (delay_bits),
        .delay_clipped (delay_clipped),
        .origin_key    (origin_key),
        .dest_key      (dest_key),
        .bucket_index  (bucket_index)
    );

    cfe_hash u_hash
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (cmd.line_done),
        .key       (hash_key),
        .busy      (hash_busy),
        .bucket    (bucket)
    );

endmodule

/* design/cfe_checker.sv */
// Port-level checker of the CSV flight record field extract unit, with its bind.
module cfe_checker
    import cfe_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          line_end,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [3:0]                    day_of_week,
    input logic                          day_valid,
    input logic signed [DELAY_BITS-1:0]  delay_value,
    input logic                          delay_clipped,
    input logic [KEY_W-1:0]              origin_key,
    input logic [KEY_W-1:0]              dest_key,
    input logic [BUCKET_BITS-1:0]        bucket_index
);

    // A result that is not taken holds its beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(origin_key) && $stable(dest_key)
            && $stable(delay_value) && $stable(bucket_index) && $stable(day_of_week))
        else $error("stalled result beat changed");

    // After a line-end beat the unit is busy hashing and takes no byte in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && line_end |=> !in_ready)
        else $error("byte accepted right after a line end");

    // The day flag agrees with the day value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (day_valid == ((day_of_week != 4'd0) && (day_of_week <= 4'd7))))
        else $error("day flag disagrees with day value");

    // A clipped delay sits at one end of the signed range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && delay_clipped |-> (delay_value == 16'sh7FFF) || (delay_value == -16'sh8000))
        else $error("clipped delay not at a range limit");

endmodule

bind csv_flight_record_field_extract_unit cfe_checker u_cfe_checker (.*);
